@@ src/rst3_pkg.sv @@
// ---------------------------------------------------------------------------
// rst3_pkg: shared types, constants and function
// Fixed-point formats, CORDIC arctangent table and the Q30 product helper.
// ---------------------------------------------------------------------------
package rst3_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int DIM           = 3;
  localparam int NEL           = DIM * DIM;
  localparam int STEPS         = 28;
  localparam int QFRAC         = 30;
  localparam int CW            = 34;                      // CORDIC / coefficient width
  localparam int PW            = CW + ELEMENT_WIDTH;      // coef * element
  localparam int SW            = PW + 4;                  // sum of nine products
  localparam int CORDIC_LAT    = STEPS + 1;
  localparam int ROT_LAT       = 2;
  localparam int MDLY          = CORDIC_LAT + ROT_LAT;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef elem_t [NEL-1:0]                 mat_t;
  typedef logic [ANGLE_WIDTH-1:0]          angle_t;
  typedef logic signed [CW-1:0]            coef_t;
  typedef coef_t [NEL-1:0]                 rmat_t;

  localparam coef_t KGAIN = 34'sd652032874;

  localparam coef_t ATAN_TURN [0:STEPS-1] = '{
    34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
    34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
    34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
    34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
    34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
    34'sh00000014, 34'sh0000000A, 34'sh00000005
  };

  // Q30 product, rounded half up (floor of product plus half an lsb).
  function automatic coef_t qmul(input coef_t a, input coef_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (68'sd1 <<< (QFRAC - 1));
    return coef_t'(p[CW+QFRAC-1:QFRAC]);
  endfunction

endpackage

@@ src/rst3_cordic.sv @@
// ---------------------------------------------------------------------------
// rst3_cordic: pipelined rotation-mode CORDIC
// One register per micro-rotation; returns sine and cosine of a binary angle.
// ---------------------------------------------------------------------------
module rst3_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  rst3_pkg::angle_t angle,
  output logic            out_vld,
  output rst3_pkg::coef_t sin_q,
  output rst3_pkg::coef_t cos_q
);
  import rst3_pkg::*;

  logic [31:0] ph;
  logic        flip_in;
  logic [31:0] ph_rot;

  logic  vld  [0:STEPS];
  logic  flip [0:STEPS];
  coef_t x    [0:STEPS];
  coef_t y    [0:STEPS];
  coef_t z    [0:STEPS];

  assign ph      = {angle, {(32-ANGLE_WIDTH){1'b0}}};
  assign flip_in = ph[31] ^ ph[30];
  assign ph_rot  = {ph[31] ^ flip_in, ph[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      flip[0] <= flip_in;
      x[0]    <= KGAIN;
      y[0]    <= '0;
      z[0]    <= coef_t'(signed'(ph_rot));
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    coef_t dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][CW-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ATAN_TURN[i];
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ATAN_TURN[i];
        end
      end
    end
  end

  assign out_vld = vld[STEPS];
  assign cos_q   = flip[STEPS] ? -x[STEPS] : x[STEPS];
  assign sin_q   = flip[STEPS] ? -y[STEPS] : y[STEPS];

endmodule

@@ src/rst3_rot.sv @@
// ---------------------------------------------------------------------------
// rst3_rot: rotation matrix builder
// Forms R = Rz * Ry * Rx from the three sine/cosine pairs in two stages.
// ---------------------------------------------------------------------------
module rst3_rot (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  rst3_pkg::coef_t sa,
  input  rst3_pkg::coef_t ca,
  input  rst3_pkg::coef_t sb,
  input  rst3_pkg::coef_t cb,
  input  rst3_pkg::coef_t sg,
  input  rst3_pkg::coef_t cg,
  output logic            out_vld,
  output rst3_pkg::rmat_t rmat
);
  import rst3_pkg::*;

  logic  vld_a;
  coef_t cb_cg, cb_sg, sa_sb, ca_sb, ca_sg, ca_cg, sa_sg, sa_cg, sa_cb, ca_cb;
  coef_t sg_a, cg_a, nsb_a;

  // stage A: first-level products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
    end
    if (en) begin
      cb_cg <= qmul(cb, cg);
      cb_sg <= qmul(cb, sg);
      sa_sb <= qmul(sa, sb);
      ca_sb <= qmul(ca, sb);
      ca_sg <= qmul(ca, sg);
      ca_cg <= qmul(ca, cg);
      sa_sg <= qmul(sa, sg);
      sa_cg <= qmul(sa, cg);
      sa_cb <= qmul(sa, cb);
      ca_cb <= qmul(ca, cb);
      sg_a  <= sg;
      cg_a  <= cg;
      nsb_a <= -sb;
    end
  end

  // stage B: second-level products and sums; index is row * 3 + column
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld_a;
    end
    if (en) begin
      rmat[0] <= cb_cg;
      rmat[3] <= cb_sg;
      rmat[6] <= nsb_a;
      rmat[1] <= qmul(sa_sb, cg_a) - ca_sg;
      rmat[4] <= qmul(sa_sb, sg_a) + ca_cg;
      rmat[7] <= sa_cb;
      rmat[2] <= qmul(ca_sb, cg_a) + sa_sg;
      rmat[5] <= qmul(ca_sb, sg_a) - sa_cg;
      rmat[8] <= ca_cb;
    end
  end

endmodule

@@ src/rst3_xform.sv @@
// ---------------------------------------------------------------------------
// rst3_xform: similarity transform datapath
// Coefficient products, element products, two-level sum, round and saturate.
// ---------------------------------------------------------------------------
module rst3_xform (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  rst3_pkg::rmat_t rmat,
  input  rst3_pkg::mat_t  m,
  output logic            out_vld,
  output rst3_pkg::mat_t  s
);
  import rst3_pkg::*;

  localparam int NT = NEL * NEL;

  logic  vld1, vld2, vld3, vld4;
  coef_t coef [0:NT-1];
  mat_t  m1;
  logic signed [PW-1:0]   prod [0:NT-1];
  logic signed [PW+1:0]   part [0:NEL*DIM-1];
  logic signed [SW-1:0]   acc  [0:NEL-1];

  // stage 1: coef(i,j,k,l) = q(R[k][i], R[l][j])
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
    if (en) begin
      m1 <= m;
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++)
          for (int k = 0; k < DIM; k++)
            for (int l = 0; l < DIM; l++)
              coef[((i*DIM+j)*DIM+k)*DIM+l] <= qmul(rmat[k*DIM+i], rmat[l*DIM+j]);
    end
  end

  // stage 2: scale each matrix element
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
    if (en) begin
      for (int t = 0; t < NT; t++)
        prod[t] <= coef[t] * m1[t % NEL];
    end
  end

  // stage 3: partial sums over l
  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
    if (en) begin
      for (int p = 0; p < NEL*DIM; p++)
        part[p] <= (PW+2)'(prod[p*DIM]) + (PW+2)'(prod[p*DIM+1])
                 + (PW+2)'(prod[p*DIM+2]);
    end
  end

  // stage 4: sums over k
  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (en) begin
      vld4 <= vld3;
    end
    if (en) begin
      for (int e = 0; e < NEL; e++)
        acc[e] <= SW'(part[e*DIM]) + SW'(part[e*DIM+1]) + SW'(part[e*DIM+2]);
    end
  end

  // stage 5: round, drop fraction, saturate
  logic signed [SW-1:0]       rnd  [0:NEL-1];
  logic signed [SW-QFRAC-1:0] shr  [0:NEL-1];
  elem_t                      sat  [0:NEL-1];

  localparam logic signed [SW-QFRAC-1:0] EMAX =
    (SW-QFRAC)'({1'b0, {(ELEMENT_WIDTH-1){1'b1}}});
  localparam logic signed [SW-QFRAC-1:0] EMIN = -EMAX - 1;

  always_comb begin
    for (int e = 0; e < NEL; e++) begin
      rnd[e] = acc[e] + (SW'(1) <<< (QFRAC - 1));
      shr[e] = rnd[e][SW-1:QFRAC];
      if (shr[e] > EMAX)      sat[e] = elem_t'(EMAX);
      else if (shr[e] < EMIN) sat[e] = elem_t'(EMIN);
      else                    sat[e] = elem_t'(shr[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld4;
    end
    if (en) begin
      for (int e = 0; e < NEL; e++)
        s[e] <= sat[e];
    end
  end

endmodule

@@ src/rotation_similarity_transform_3x3_top.sv @@
// ---------------------------------------------------------------------------
// rotation_similarity_transform_3x3_top
// Rotates a Q16.16 3x3 matrix by Euler angles: S = R' * M * R, saturated.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  input   | in_valid / in_stall     | m_r*_c* (Q16.16), angle_x/y/z
//  output  | out_valid / out_stall   | out_r*_c* (Q16.16, saturated)
//
//  One item enters per cycle while in_stall is low; the pipeline is CORDIC prep plus 28
//  micro-rotation stages, 2 rotation-matrix stages and 5 transform stages.
//  The whole pipeline advances as one: it holds when the output register is
//  full and stalled, and in_stall is raised in exactly those cycles.
//  Reset clears only the valid bits; the data registers are not reset.
// ---------------------------------------------------------------------------
module rotation_similarity_transform_3x3_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rst3_pkg::elem_t  m_r0_c0,
  input  rst3_pkg::elem_t  m_r0_c1,
  input  rst3_pkg::elem_t  m_r0_c2,
  input  rst3_pkg::elem_t  m_r1_c0,
  input  rst3_pkg::elem_t  m_r1_c1,
  input  rst3_pkg::elem_t  m_r1_c2,
  input  rst3_pkg::elem_t  m_r2_c0,
  input  rst3_pkg::elem_t  m_r2_c1,
  input  rst3_pkg::elem_t  m_r2_c2,
  input  rst3_pkg::angle_t angle_x,
  input  rst3_pkg::angle_t angle_y,
  input  rst3_pkg::angle_t angle_z,
  output logic             out_valid,
  input  logic             out_stall,
  output rst3_pkg::elem_t  out_r0_c0,
  output rst3_pkg::elem_t  out_r0_c1,
  output rst3_pkg::elem_t  out_r0_c2,
  output rst3_pkg::elem_t  out_r1_c0,
  output rst3_pkg::elem_t  out_r1_c1,
  output rst3_pkg::elem_t  out_r1_c2,
  output rst3_pkg::elem_t  out_r2_c0,
  output rst3_pkg::elem_t  out_r2_c1,
  output rst3_pkg::elem_t  out_r2_c2
);
  import rst3_pkg::*;

  logic  en;
  mat_t  m_in;
  mat_t  m_dly [0:MDLY-1];
  logic  vx, vy, vz, vr;
  coef_t sa, ca, sb, cb, sg, cg;
  rmat_t rmat;
  mat_t  s;

  // advance unless a finished item sits stalled at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign m_in = {m_r2_c2, m_r2_c1, m_r2_c0, m_r1_c2, m_r1_c1, m_r1_c0,
                 m_r0_c2, m_r0_c1, m_r0_c0};

  // delay the matrix to meet the rotation coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      m_dly[0] <= m_in;
      for (int d = 1; d < MDLY; d++)
        m_dly[d] <= m_dly[d-1];
    end
  end

  rst3_cordic u_cordic_x (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid), .angle(angle_x),
    .out_vld(vx), .sin_q(sa), .cos_q(ca)
  );
  rst3_cordic u_cordic_y (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid), .angle(angle_y),
    .out_vld(vy), .sin_q(sb), .cos_q(cb)
  );
  rst3_cordic u_cordic_z (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid), .angle(angle_z),
    .out_vld(vz), .sin_q(sg), .cos_q(cg)
  );

  rst3_rot u_rot (
    .clk(clk), .rst(rst), .en(en), .in_vld(vx),
    .sa(sa), .ca(ca), .sb(sb), .cb(cb), .sg(sg), .cg(cg),
    .out_vld(vr), .rmat(rmat)
  );

  rst3_xform u_xform (
    .clk(clk), .rst(rst), .en(en), .in_vld(vr), .rmat(rmat),
    .m(m_dly[MDLY-1]), .out_vld(out_valid), .s(s)
  );

  assign out_r0_c0 = s[0];
  assign out_r0_c1 = s[1];
  assign out_r0_c2 = s[2];
  assign out_r1_c0 = s[3];
  assign out_r1_c1 = s[4];
  assign out_r1_c2 = s[5];
  assign out_r2_c0 = s[6];
  assign out_r2_c1 = s[7];
  assign out_r2_c2 = s[8];

  // the three CORDIC lanes move in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (vx == vy) && (vy == vz))
    else $error("CORDIC lane valid bits diverged");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(s))
    else $error("stalled result changed");

  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

endmodule
